@@ rtl/ttn_pkg.sv @@
// ----------------------------------------------------------------------------
// ttn_pkg
// shared types, codes and helpers for the two-tree neighbor calculator
// ----------------------------------------------------------------------------
package ttn_pkg;

  // internal rank width: covers the widened second tree (up to 511)
  localparam int RANK_W = 10;

  typedef logic [RANK_W-1:0] rank_t;

  // neighbor value with a separate "none" mark
  typedef struct packed {
    logic  none;
    rank_t val;
  } nbr_t;

  // step unit operations
  typedef logic [1:0] step_op_t;
  localparam step_op_t OP_UP     = 2'd0;
  localparam step_op_t OP_LEFT   = 2'd1;
  localparam step_op_t OP_RSTART = 2'd2;
  localparam step_op_t OP_DOWN   = 2'd3;

  typedef struct packed {
    nbr_t nxt;
    logic done;
  } step_out_t;

  // configuration register indexes
  localparam logic [7:0] CFG_WORLD_SIZE = 8'd0;
  localparam logic [7:0] CFG_ROOT_RANK  = 8'd1;

  // two's complement encodings of "none" on the result ports
  localparam logic [8:0] NBR_NONE   = 9'h1FF;
  localparam logic [1:0] COLOR_NONE = 2'b11;

  function automatic logic [8:0] nbr_to_port(input nbr_t n);
    nbr_to_port = n.none ? NBR_NONE : n.val[8:0];
  endfunction

  // parity of the bits above the lowest set bit
  function automatic logic colour_bit(input rank_t c);
    colour_bit = ^(c & (c - rank_t'(1)));
  endfunction

endpackage

@@ rtl/ttn_step_unit.sv @@
// ----------------------------------------------------------------------------
// ttn_step_unit
// one tree step: parent hop, left child, right child start, left-spine descent
// ----------------------------------------------------------------------------
module ttn_step_unit (
  input  ttn_pkg::step_op_t  op,
  input  ttn_pkg::rank_t     cur,
  input  ttn_pkg::rank_t     wsize,
  input  ttn_pkg::rank_t     mask,
  output ttn_pkg::step_out_t res
);

  ttn_pkg::rank_t lsb;
  ttn_pkg::rank_t up_v;
  ttn_pkg::rank_t left_v;
  ttn_pkg::rank_t rs_v;

  assign lsb    = cur & (~cur + ttn_pkg::rank_t'(1));
  assign up_v   = ((cur & ~lsb) | (lsb << 1)) & mask;
  assign left_v = (cur & ~lsb) | (lsb >> 1);
  assign rs_v   = cur | (lsb >> 1);

  always_comb begin
    res.nxt.none = 1'b0;
    res.nxt.val  = cur;
    res.done     = 1'b1;
    case (op)
      ttn_pkg::OP_UP: begin
        if (cur == '0) begin
          res.nxt.none = 1'b1;
        end else begin
          res.nxt.val = up_v;
          res.done    = (up_v < wsize);
        end
      end
      ttn_pkg::OP_LEFT: begin
        if (cur == '0) begin
          // top of the tree: highest power of two inside the mask
          res.nxt.val = (mask >> 1) + ttn_pkg::rank_t'(1);
        end else if (lsb[0]) begin
          res.nxt.none = 1'b1;
        end else begin
          res.nxt.val = left_v;
        end
      end
      ttn_pkg::OP_RSTART: begin
        if (cur == '0 || lsb[0]) begin
          res.nxt.none = 1'b1;
        end else begin
          res.nxt.val = rs_v;
          res.done    = (rs_v < wsize);
        end
      end
      default: begin
        // descend the left spine while out of range
        if (lsb[0]) begin
          res.nxt.none = 1'b1;
        end else begin
          res.nxt.val = left_v;
          res.done    = (left_v < wsize);
        end
      end
    endcase
  end

endmodule

@@ rtl/two_tree_neighbor_calc_core.sv @@
// ----------------------------------------------------------------------------
// two_tree_neighbor_calc_core
// parent, children, leaf flag and edge colors of one rank in both trees
// ----------------------------------------------------------------------------
// ranks are handled one at a time, from input transfer to result; the parent and
//   right-child walks go one tree level per cycle through the single shared step
//   unit, so the walk depth sets how long a rank takes
// a waiting result sits in the output register while the next rank is taken
// reset (rst, synchronous): world_size = 2, root_rank = 0, sequencer idle
module two_tree_neighbor_calc_core #(
  parameter int MAX_NODES = 256
) (
  input  logic              clk,
  input  logic              rst,
  // configuration write channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_index,
  input  logic [8:0]        cfg_data,
  // rank input channel
  input  logic              node_valid,
  output logic              node_stall,
  input  logic [7:0]        node_rank,
  // result channel
  output logic              result_valid,
  input  logic              result_stall,
  output logic signed [8:0] t1_parent,
  output logic signed [8:0] t1_left,
  output logic signed [8:0] t1_right,
  output logic signed [8:0] t2_parent,
  output logic signed [8:0] t2_left,
  output logic signed [8:0] t2_right,
  output logic              leaf_in_first,
  output logic signed [1:0] color_first,
  output logic signed [1:0] color_second
);

  // wide enough to hold any MAX_NODES value for the clamp compare
  localparam logic [16:0] MAX_W = 17'(MAX_NODES);

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_P1   = 3'd1;
  localparam logic [2:0] S_L1   = 3'd2;
  localparam logic [2:0] S_R1   = 3'd3;
  localparam logic [2:0] S_P2   = 3'd4;
  localparam logic [2:0] S_L2   = 3'd5;
  localparam logic [2:0] S_R2   = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  // configuration registers
  logic [8:0] world_size;
  logic [7:0] root_rank;

  // sequencer state and working registers
  logic [2:0]      state;
  logic            first;
  logic [7:0]      rank;
  ttn_pkg::rank_t  cur;
  ttn_pkg::nbr_t   p1, l1, r1, p2, l2, r2;

  // derived world geometry
  ttn_pkg::rank_t  w_eff;
  ttn_pkg::rank_t  w2;
  ttn_pkg::rank_t  mask1;
  ttn_pkg::rank_t  mask2;
  ttn_pkg::rank_t  x1;
  ttn_pkg::rank_t  x2;
  logic            odd;
  logic            in_t2;

  // shared step unit hookup
  ttn_pkg::step_op_t  op;
  ttn_pkg::rank_t     wsel;
  ttn_pkg::rank_t     msel;
  ttn_pkg::step_out_t step;

  // finishing logic
  ttn_pkg::nbr_t p2f, l1f, r1f, l2f, r2f;
  logic          rank_oor;
  logic          leaf_c;
  logic          c1_none, c1_bit, c2_none, c2_bit;

  logic node_xfer;
  logic out_free;

  assign cfg_ready  = 1'b1;
  assign node_stall = (state != S_IDLE);
  assign node_xfer  = node_valid && !node_stall;
  assign out_free   = !result_valid || !result_stall;

  // clamp the world size into the supported range
  always_comb begin
    if (world_size < 9'd2) begin
      w_eff = ttn_pkg::rank_t'(2);
    end else if ({8'b0, world_size} > MAX_W) begin
      w_eff = MAX_W[ttn_pkg::RANK_W-1:0];
    end else begin
      w_eff = {1'b0, world_size};
    end
  end

  assign odd = w_eff[0];
  // even worlds use a tree over one more node
  assign w2  = odd ? w_eff : (w_eff + ttn_pkg::rank_t'(1));

  function automatic ttn_pkg::rank_t smear_mask(input ttn_pkg::rank_t w);
    ttn_pkg::rank_t v;
    v = w - ttn_pkg::rank_t'(1);
    v = v | (v >> 1);
    v = v | (v >> 2);
    v = v | (v >> 4);
    v = v | (v >> 8);
    smear_mask = v;
  endfunction

  assign mask1 = smear_mask(w_eff);
  assign mask2 = smear_mask(w2);

  // starting ranks: plain for tree one, mirrored or shifted for tree two
  assign x1 = {2'b0, rank};
  always_comb begin
    if (rank == 8'd0) begin
      x2 = '0;
    end else if (odd) begin
      x2 = w_eff - x1;
    end else begin
      x2 = x1 + ttn_pkg::rank_t'(1);
    end
  end

  // pick the operation and tree for the current state
  always_comb begin
    in_t2 = (state inside {S_P2, S_L2, S_R2});
    case (state)
      S_P1, S_P2: op = ttn_pkg::OP_UP;
      S_L1, S_L2: op = ttn_pkg::OP_LEFT;
      S_R1, S_R2: op = first ? ttn_pkg::OP_RSTART : ttn_pkg::OP_DOWN;
      default:    op = ttn_pkg::OP_UP;
    endcase
    wsel = in_t2 ? w2 : w_eff;
    msel = in_t2 ? mask2 : mask1;
  end

  ttn_step_unit u_step (
    .op    (op),
    .cur   (cur),
    .wsize (wsel),
    .mask  (msel),
    .res   (step)
  );

  // configuration writes, taken whenever offered
  always_ff @(posedge clk) begin
    if (rst) begin
      world_size <= 9'd2;
      root_rank  <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ttn_pkg::CFG_WORLD_SIZE: world_size <= cfg_data;
        ttn_pkg::CFG_ROOT_RANK:  root_rank  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // sequencer: parent walk, left child, right walk, per tree
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      first <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (node_xfer) begin
            state <= S_P1;
          end
        end
        S_P1: begin
          if (step.done) begin
            state <= S_L1;
          end
        end
        S_L1: begin
          state <= S_R1;
          first <= 1'b1;
        end
        S_R1: begin
          first <= 1'b0;
          if (step.done) begin
            state <= S_P2;
          end
        end
        S_P2: begin
          if (step.done) begin
            state <= S_L2;
          end
        end
        S_L2: begin
          state <= S_R2;
          first <= 1'b1;
        end
        S_R2: begin
          first <= 1'b0;
          if (step.done) begin
            state <= S_DONE;
          end
        end
        default: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  // walk datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (node_xfer) begin
          rank <= node_rank;
          cur  <= {2'b0, node_rank};
        end
      end
      S_P1: begin
        if (step.done) begin
          p1  <= step.nxt;
          cur <= x1;
        end else begin
          cur <= step.nxt.val;
        end
      end
      S_L1: begin
        l1  <= step.nxt;
        cur <= x1;
      end
      S_R1: begin
        if (step.done) begin
          r1  <= step.nxt;
          cur <= x2;
        end else begin
          cur <= step.nxt.val;
        end
      end
      S_P2: begin
        if (step.done) begin
          p2  <= step.nxt;
          cur <= x2;
        end else begin
          cur <= step.nxt.val;
        end
      end
      S_L2: begin
        l2  <= step.nxt;
        cur <= x2;
      end
      S_R2: begin
        if (step.done) begin
          r2 <= step.nxt;
        end else begin
          cur <= step.nxt.val;
        end
      end
      default: ;
    endcase
  end

  function automatic ttn_pkg::nbr_t mirror(input ttn_pkg::nbr_t x,
                                           input ttn_pkg::rank_t w);
    mirror = x;
    if (!x.none && x.val != '0) begin
      mirror.val = w - x.val;
    end
  endfunction

  function automatic ttn_pkg::nbr_t unshift(input ttn_pkg::nbr_t x);
    unshift = x;
    if (!x.none) begin
      unshift.val = x.val - ttn_pkg::rank_t'(1);
    end
  endfunction

  // map tree two back to real ranks, drop children equal to the root,
  // then derive leaf flag and edge colors
  always_comb begin
    if (odd) begin
      p2f = mirror(p2, w_eff);
      l2f = mirror(l2, w_eff);
      r2f = mirror(r2, w_eff);
    end else begin
      // shifted parent of rank zero stays zero
      p2f = (p2.val == '0) ? p2 : unshift(p2);
      l2f = unshift(l2);
      r2f = unshift(r2);
    end
    l1f = l1;
    r1f = r1;
    if (!l1f.none && l1f.val == {2'b0, root_rank}) l1f.none = 1'b1;
    if (!r1f.none && r1f.val == {2'b0, root_rank}) r1f.none = 1'b1;
    if (!l2f.none && l2f.val == {2'b0, root_rank}) l2f.none = 1'b1;
    if (!r2f.none && r2f.val == {2'b0, root_rank}) r2f.none = 1'b1;

    rank_oor = ({2'b0, rank} >= w_eff);
    leaf_c   = l1f.none && r1f.none;

    c1_none = 1'b1;
    c1_bit  = 1'b0;
    c2_none = 1'b1;
    c2_bit  = 1'b0;
    if (!leaf_c) begin
      c1_none = 1'b0;
      c1_bit  = !l1f.none ? ttn_pkg::colour_bit(l1f.val)
                          : ~ttn_pkg::colour_bit(r1f.val);
    end else if (!l2f.none) begin
      c2_none = 1'b0;
      c2_bit  = ~ttn_pkg::colour_bit(l2f.val);
    end else if (!r2f.none) begin
      c2_none = 1'b0;
      c2_bit  = ttn_pkg::colour_bit(r2f.val);
    end
    // at the root the second tree takes the opposite color
    if (rank == root_rank && !c1_none) begin
      c2_none = 1'b0;
      c2_bit  = ~c1_bit;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      if (rank_oor) begin
        t1_parent     <= ttn_pkg::NBR_NONE;
        t1_left       <= ttn_pkg::NBR_NONE;
        t1_right      <= ttn_pkg::NBR_NONE;
        t2_parent     <= ttn_pkg::NBR_NONE;
        t2_left       <= ttn_pkg::NBR_NONE;
        t2_right      <= ttn_pkg::NBR_NONE;
        leaf_in_first <= 1'b1;
        color_first   <= ttn_pkg::COLOR_NONE;
        color_second  <= ttn_pkg::COLOR_NONE;
      end else begin
        t1_parent     <= ttn_pkg::nbr_to_port(p1);
        t1_left       <= ttn_pkg::nbr_to_port(l1f);
        t1_right      <= ttn_pkg::nbr_to_port(r1f);
        t2_parent     <= ttn_pkg::nbr_to_port(p2f);
        t2_left       <= ttn_pkg::nbr_to_port(l2f);
        t2_right      <= ttn_pkg::nbr_to_port(r2f);
        leaf_in_first <= leaf_c;
        color_first   <= c1_none ? ttn_pkg::COLOR_NONE : {1'b0, c1_bit};
        color_second  <= c2_none ? ttn_pkg::COLOR_NONE : {1'b0, c2_bit};
      end
    end
  end

  // a new result only comes out of the finish state
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_DONE)
    else $error("result appeared outside the finish state");

  // an accepted rank starts the first-tree parent walk
  a_accept_starts_walk: assert property (@(posedge clk) disable iff (rst)
    node_xfer |=> state == S_P1)
    else $error("accepted rank did not start the walk");

  // leaf flag matches the first-tree children
  a_leaf_matches: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> leaf_in_first ==
      (t1_left == ttn_pkg::NBR_NONE && t1_right == ttn_pkg::NBR_NONE))
    else $error("leaf flag disagrees with first-tree children");

  // first-tree color is assigned exactly for non-leaf nodes
  a_color_first_leaf: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (color_first == ttn_pkg::COLOR_NONE) == leaf_in_first)
    else $error("first-tree color inconsistent with leaf flag");

endmodule
